/* hw/rtl/lsac_pkg.sv */
// lsac_pkg: shared types and constants for the LRU set-associative cache simulator.
// Used by lru_set_assoc_cache_sim and its checker; depends on nothing.
package lsac_pkg;

  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;

  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 32;
  localparam int CMD_W        = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int SET_BITS_W   = 3;
  localparam int WAYS_W       = 4;
  localparam int BLOCK_BITS_W = 6;
  localparam int SHAMT_W      = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSN   = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_STORE  = 2'd2,
    CMD_MODIFY = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK
  } state_t;

endpackage

/* hw/rtl/lru_set_assoc_cache_sim.sv */
// lru_set_assoc_cache_sim: trace-driven LRU set-associative cache model in hardware.
// Depends on lsac_pkg (types, constants); checked by lsac_checker (bound in).
//
// Usage:
//   Command channel: drive command/address with start high; the transaction is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done pulses for exactly one cycle with the hit/miss/evict
//   flags; the totals ports always show the running saturating counts. The
//   receiver cannot stall, so results are never held back.
//   Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; cfg_ready is
//   always high. Index 0 set_bits, 1 ways, 2 block_bits; other indexes drop.
//   Write config only while no transaction is in flight.
// Timing:
//   The accept edge reads the set's row from the set memory; the next edge
//   registers the result and done and, for load/store/modify, writes the
//   row back with updated tags/ages.
//   A new transaction is taken while done is shown; none is taken during
//   the single read-modify-write of the set memory.
// Reset:
//   Synchronous rst clears counters and config to defaults, then a clearing
//   pass writes all 2**MAX_SET_BITS set rows (64 by default) empty, with
//   busy high. Config writes are taken during the pass.
module lru_set_assoc_cache_sim #(
  parameter int MAX_SET_BITS = lsac_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = lsac_pkg::DEF_MAX_WAYS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [lsac_pkg::CMD_W-1:0]      command,
  input  logic [lsac_pkg::ADDR_W-1:0]     address,
  output logic                            done,
  output logic                            first_hit,
  output logic                            first_miss,
  output logic                            evicted,
  output logic                            second_hit,
  output logic [lsac_pkg::CNT_W-1:0]      hit_total,
  output logic [lsac_pkg::CNT_W-1:0]      miss_total,
  output logic [lsac_pkg::CNT_W-1:0]      eviction_total,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lsac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lsac_pkg::*;

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_W    = WAY_W;
  localparam int NV_W     = $clog2(MAX_WAYS + 1);
  localparam int SB_W     = (MAX_SET_BITS > 0) ? $clog2(MAX_SET_BITS + 1) : 1;

  // One row holds a whole set: tags, valid bits and LRU ranks (0 = most recent).
  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDR_W-1:0] tags;
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0]  ages;
  } row_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                input logic [1:0] inc);
    logic [CNT_W:0] s;
    s = {1'b0, v} + (CNT_W + 1)'(inc);
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  state_t state, state_next;
  logic [SET_W-1:0] clr_idx;
  logic             clr_last;

  // Config registers
  logic [SET_BITS_W-1:0]   set_bits;
  logic [WAYS_W-1:0]       ways;
  logic [BLOCK_BITS_W-1:0] block_bits;
  logic [SB_W-1:0]         sb_eff;
  logic [NV_W-1:0]         wy_eff;

  // Address split
  logic [SHAMT_W-1:0] shamt;
  logic [ADDR_W-1:0]  tag_in;
  logic [ADDR_W-1:0]  addr_sh;
  logic [SET_W-1:0]   set_in;
  logic               accept;

  // Held transaction
  cmd_t              cmd_q;
  logic [ADDR_W-1:0] tag_q;
  logic [SET_W-1:0]  set_q;
  logic              is_access;

  // Set memory
  row_t             mem [NUM_SETS];
  row_t             rdata;
  logic             mem_we;
  logic [SET_W-1:0] mem_waddr;
  row_t             mem_wdata;

  // Lookup results
  logic             hit_any;
  logic [WAY_W-1:0] hit_way;
  logic [NV_W-1:0]  nvalid;
  logic             free_any;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] vic_way;
  logic [AGE_W-1:0] vic_age;
  logic             vic_any;
  logic             do_fill;
  logic             do_evict;
  logic [WAY_W-1:0] tgt;
  logic [AGE_W-1:0] old_age;
  logic             age_all;
  row_t             row_upd;
  logic [1:0]       hit_inc;

  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] eviction_count;

  assign cfg_ready      = 1'b1;
  assign accept         = start && !busy;
  assign clr_last       = (clr_idx == SET_W'(NUM_SETS - 1));
  assign is_access      = (cmd_q != CMD_INSN);
  assign hit_total      = hit_count;
  assign miss_total     = miss_count;
  assign eviction_total = eviction_count;

  // Clamp config to the built geometry.
  always_comb begin
    if (int'(set_bits) > MAX_SET_BITS) begin
      sb_eff = SB_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SB_W'(set_bits);
    end
    if (ways == '0) begin
      wy_eff = NV_W'(1);
    end else if (int'(ways) > MAX_WAYS) begin
      wy_eff = NV_W'(MAX_WAYS);
    end else begin
      wy_eff = NV_W'(ways);
    end
  end

  // Split the incoming address; a tag shift of 64 or more yields zero.
  always_comb begin
    shamt   = SHAMT_W'(sb_eff) + SHAMT_W'(block_bits);
    tag_in  = (shamt >= SHAMT_W'(ADDR_W)) ? '0 : (address >> shamt);
    addr_sh = address >> block_bits;
    for (int j = 0; j < SET_W; j++) begin
      set_in[j] = addr_sh[j] && (j < int'(sb_eff));
    end
  end

  // Scan the set row: first matching way, valid count, first free way, and
  // the oldest valid way (first one wins on a tie).
  always_comb begin
    hit_any  = 1'b0;
    hit_way  = '0;
    nvalid   = '0;
    free_any = 1'b0;
    free_way = '0;
    vic_way  = '0;
    vic_age  = '0;
    vic_any  = 1'b0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (rdata.valid[i]) begin
        nvalid = nvalid + NV_W'(1);
        if (!hit_any && rdata.tags[i] == tag_q) begin
          hit_any = 1'b1;
          hit_way = WAY_W'(i);
        end
        if (!vic_any || rdata.ages[i] > vic_age) begin
          vic_any = 1'b1;
          vic_way = WAY_W'(i);
          vic_age = rdata.ages[i];
        end
      end else if (!free_any) begin
        free_any = 1'b1;
        free_way = WAY_W'(i);
      end
    end
  end

  // Pick the way to promote and build the updated row.
  always_comb begin
    do_fill  = !hit_any && (nvalid < wy_eff);
    do_evict = !hit_any && !do_fill;
    priority if (hit_any) begin
      tgt     = hit_way;
      old_age = rdata.ages[hit_way];
      age_all = 1'b0;
    end else if (do_fill) begin
      tgt     = free_way;
      old_age = '0;
      age_all = 1'b1;
    end else begin
      tgt     = vic_way;
      old_age = vic_age;
      age_all = 1'b0;
    end

    row_upd = rdata;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_W'(i) == tgt) begin
        row_upd.ages[i] = '0;
      end else if (rdata.valid[i] && (age_all || rdata.ages[i] < old_age)) begin
        row_upd.ages[i] = rdata.ages[i] + AGE_W'(1);
      end
    end
    if (do_fill) begin
      row_upd.valid[tgt] = 1'b1;
    end
    if (!hit_any) begin
      row_upd.tags[tgt] = tag_q;
    end

    hit_inc = {1'b0, hit_any} + {1'b0, (cmd_q == CMD_MODIFY)};
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // State outputs: busy and the memory write port
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = row_upd;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_LOOK: begin
        mem_we = is_access;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Set memory: the write lands before the next read can issue,
  // so back-to-back hits on one set need no forwarding.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rdata <= mem[set_in];
    end
  end

  // Control, config and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_idx        <= '0;
      set_bits       <= SET_BITS_W'(4);
      ways           <= WAYS_W'(1);
      block_bits     <= BLOCK_BITS_W'(4);
      hit_count      <= '0;
      miss_count     <= '0;
      eviction_count <= '0;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_LOOK);
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_SET_BITS:   set_bits   <= cfg_data[SET_BITS_W-1:0];
          CFG_WAYS:       ways       <= cfg_data[WAYS_W-1:0];
          CFG_BLOCK_BITS: block_bits <= cfg_data[BLOCK_BITS_W-1:0];
          default:        ;
        endcase
      end
      if (state == ST_LOOK && is_access) begin
        hit_count      <= sat_add(hit_count, hit_inc);
        miss_count     <= sat_add(miss_count, {1'b0, !hit_any});
        eviction_count <= sat_add(eviction_count, {1'b0, do_evict});
      end
    end
  end

  // Transaction payload and result flags
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(command);
      tag_q <= tag_in;
      set_q <= set_in;
    end
    if (state == ST_LOOK) begin
      first_hit  <= is_access && hit_any;
      first_miss <= is_access && !hit_any;
      evicted    <= is_access && do_evict;
      second_hit <= (cmd_q == CMD_MODIFY);
    end
  end

endmodule

/* hw/rtl/lsac_checker.sv */
// lsac_checker: port-level assertions for lru_set_assoc_cache_sim, bound to the top level.
// Depends on lsac_pkg for widths.
module lsac_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       first_hit,
  input logic                       first_miss,
  input logic                       evicted,
  input logic [lsac_pkg::CNT_W-1:0] hit_total,
  input logic [lsac_pkg::CNT_W-1:0] miss_total
);
  import lsac_pkg::*;

  // An accepted transaction raises busy and then shows its result with done.
  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy ##1 done)
    else $error("result strobe not two cycles after accept");

  a_hit_xor_miss: assert property (@(posedge clk) disable iff (rst)
    done |-> !(first_hit && first_miss))
    else $error("hit and miss flagged together");

  a_evict_needs_miss: assert property (@(posedge clk) disable iff (rst)
    done && evicted |-> first_miss)
    else $error("eviction without a miss");

  a_hits_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> hit_total >= $past(hit_total))
    else $error("hit total went down");

  a_miss_moves_with_result: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(miss_total) |-> done && first_miss)
    else $error("miss total changed without a miss result");

endmodule

bind lru_set_assoc_cache_sim lsac_checker u_lsac_checker (.*);
